@@ hdl/prq_pkg.sv @@
// Shared types and constants for the priority ready queue.
`timescale 1ns / 1ps
package prq_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_QUERY  = 3'd2,
    OP_GET    = 3'd3,
    OP_CLEAR  = 3'd4
  } prq_op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NOT_QUEUED = 2'd2,
    ST_QUEUED     = 2'd3
  } prq_status_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [5:0] thread_id;
    logic [5:0] priority_req;
    logic       at_tail;
  } prq_in_t;

  typedef struct packed {
    logic [5:0] found_thread;
    logic [1:0] status;
    logic [5:0] highest_priority;
    logic       any_ready;
    logic [6:0] ready_count;
  } prq_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DECIDE,
    S_LINK,
    S_SCAN,
    S_DONE
  } prq_state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic latch;    // capture the input item
    logic rd;       // issue first reads
    logic decide;   // do the update
    logic link;     // second link write for middle removal
    logic scan;     // one step of the bitmap scan
    logic scan_init;
    logic emit;
  } prq_cmd_t;

  typedef struct packed {
    logic need_link;
    logic scan_done;
  } prq_stat_t;

endpackage

@@ hdl/prq_ram.sv @@
// Generic single-write RAM with registered read.
`timescale 1ns / 1ps
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/prq_datapath.sv @@
// Datapath: link memories, queued bits, bitmap, count and result register.
`timescale 1ns / 1ps
module prq_datapath import prq_pkg::*; #(
  parameter int NUM_LEVELS  = 64,
  parameter int NUM_THREADS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  prq_in_t   in_data,
  input  prq_cmd_t  cmd,
  output prq_stat_t stat,
  output prq_out_t  res
);
  localparam int LW = (NUM_LEVELS > 2) ? $clog2(NUM_LEVELS) : 1;
  localparam int TW = (NUM_THREADS > 2) ? $clog2(NUM_THREADS) : 1;
  localparam int CW = $clog2(NUM_THREADS + 1);
  localparam int SCAN_W = 8;
  localparam int NCHUNK = (NUM_LEVELS + SCAN_W - 1) / SCAN_W;
  localparam int KW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  prq_in_t item_r;
  logic [LW-1:0] lvl_r;
  logic [TW-1:0] tid_r;
  logic tid_ok_r;

  logic [NUM_LEVELS-1:0] bitmap_r;
  logic [NUM_THREADS-1:0] queued_r;
  logic [CW-1:0] count_r;

  logic [5:0] found_r;
  logic [1:0] status_r;
  logic [KW:0] chunk_r;
  logic hp_found_r;
  logic [LW-1:0] hp_r;
  logic [TW-1:0] mid_prev_r, mid_next_r;

  // Memory ports
  logic hd_we, tl_we, nx_we, pv_we, lv_we;
  logic [LW-1:0] hd_wa, tl_wa, hd_ra, tl_ra, lv_wd;
  logic [TW-1:0] hd_wd, tl_wd, nx_wa, nx_wd, pv_wa, pv_wd, nx_ra, pv_ra, lv_wa, lv_ra;
  logic [TW-1:0] hd_rd, tl_rd, nx_rd, pv_rd;
  logic [LW-1:0] lv_rd;

  prq_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_head (.clk, .we(hd_we), .waddr(hd_wa),
    .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
  prq_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_tail (.clk, .we(tl_we), .waddr(tl_wa),
    .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));
  prq_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_next (.clk, .we(nx_we), .waddr(nx_wa),
    .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  prq_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_prev (.clk, .we(pv_we), .waddr(pv_wa),
    .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
  prq_ram #(.WIDTH(LW), .DEPTH(NUM_THREADS)) u_lvl (.clk, .we(lv_we), .waddr(lv_wa),
    .wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd));

  // Level and thread of the current item, clamped and truncated.
  logic [LW-1:0] in_lvl;
  logic in_tid_ok;
  always_comb begin
    if ({26'd0, in_data.priority_req} >= NUM_LEVELS) in_lvl = LW'(NUM_LEVELS - 1);
    else in_lvl = LW'(in_data.priority_req);
    in_tid_ok = {26'd0, in_data.thread_id} < NUM_THREADS;
  end

  // Remove path: the thread's level comes from the first read, so head and
  // tail reads of that level are issued in the decide-preceding read cycle.
  logic is_ins, is_rem, rem_live, ins_live;
  logic lvl_ne_ins;
  logic [LW-1:0] rlvl;
  always_comb begin
    is_ins = item_r.operation == OP_INSERT;
    is_rem = item_r.operation == OP_REMOVE;
    ins_live = is_ins && tid_ok_r && !queued_r[tid_r];
    rem_live = is_rem && tid_ok_r && queued_r[tid_r];
    rlvl = is_rem ? lv_rd : lvl_r;
    lvl_ne_ins = bitmap_r[lvl_r];
  end

  logic rm_head, rm_tail;
  always_comb begin
    rm_head = hd_rd == tid_r;
    rm_tail = tl_rd == tid_r;
    stat.need_link = rem_live && !rm_head && !rm_tail;
    stat.scan_done = chunk_r >= (KW+1)'(NCHUNK) || hp_found_r;
  end

  // Read address selection: in READ the level ram answers; in DECIDE head,
  // tail, next and prev of the right level/thread are valid.
  always_comb begin
    lv_ra = cmd.latch ? TW'(in_data.thread_id) : tid_r;
    hd_ra = cmd.rd ? (is_rem ? lv_rd : lvl_r) : lvl_r;
    tl_ra = hd_ra;
    nx_ra = tid_r;
    pv_ra = tid_r;
  end

  always_comb begin
    hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; lv_we = 1'b0;
    hd_wa = rlvl; tl_wa = rlvl; hd_wd = tid_r; tl_wd = tid_r;
    nx_wa = tid_r; nx_wd = tid_r; pv_wa = tid_r; pv_wd = tid_r;
    lv_wa = tid_r; lv_wd = lvl_r;
    if (cmd.decide && ins_live) begin
      lv_we = 1'b1;
      if (!lvl_ne_ins) begin
        hd_we = 1'b1; tl_we = 1'b1;
      end else if (item_r.at_tail) begin
        nx_we = 1'b1; nx_wa = tl_rd; nx_wd = tid_r;
        pv_we = 1'b1; pv_wa = tid_r; pv_wd = tl_rd;
        tl_we = 1'b1;
      end else begin
        pv_we = 1'b1; pv_wa = hd_rd; pv_wd = tid_r;
        nx_we = 1'b1; nx_wa = tid_r; nx_wd = hd_rd;
        hd_we = 1'b1;
      end
    end else if (cmd.decide && rem_live) begin
      if (rm_head && !rm_tail) begin
        hd_we = 1'b1; hd_wd = nx_rd;
      end else if (rm_tail && !rm_head) begin
        tl_we = 1'b1; tl_wd = pv_rd;
      end else if (!rm_head && !rm_tail) begin
        nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
      end
    end else if (cmd.link) begin
      pv_we = 1'b1; pv_wa = mid_next_r; pv_wd = mid_prev_r;
    end
  end

  // Bitmap chunk for the scan.
  logic [SCAN_W-1:0] chunk_bits;
  logic [NCHUNK*SCAN_W-1:0] bm_pad;
  logic chunk_any;
  logic [2:0] chunk_pos;
  always_comb begin
    bm_pad = '0;
    bm_pad[NUM_LEVELS-1:0] = bitmap_r;
    chunk_bits = bm_pad[chunk_r[KW-1:0]*SCAN_W +: SCAN_W];
    chunk_any = |chunk_bits;
    chunk_pos = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (chunk_bits[i]) chunk_pos = 3'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
      lvl_r <= in_lvl;
      tid_r <= TW'(in_data.thread_id);
      tid_ok_r <= in_tid_ok;
    end
    if (cmd.decide) begin
      mid_prev_r <= pv_rd;
      mid_next_r <= nx_rd;
      found_r <= '0;
      status_r <= ST_OK;
      case (item_r.operation)
        OP_INSERT: begin
          if (!tid_ok_r) status_r <= ST_NOT_QUEUED;
          else if (queued_r[tid_r]) status_r <= ST_QUEUED;
        end
        OP_REMOVE: begin
          if (!rem_live) status_r <= ST_NOT_QUEUED;
        end
        OP_QUERY: begin
          if (bitmap_r == '0) status_r <= ST_EMPTY;
        end
        OP_GET: begin
          if (!bitmap_r[lvl_r]) status_r <= ST_EMPTY;
          else found_r <= 6'(item_r.at_tail ? tl_rd : hd_rd);
        end
        default: ;
      endcase
    end
    if (cmd.scan_init) begin
      hp_r <= '0;
    end else if (cmd.scan && chunk_any && !hp_found_r) begin
      hp_r <= LW'({chunk_r[KW-1:0], chunk_pos});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r <= '0;
      queued_r <= '0;
      count_r <= '0;
      chunk_r <= '0;
      hp_found_r <= 1'b0;
    end else begin
      if (cmd.decide) begin
        if (ins_live) begin
          bitmap_r[lvl_r] <= 1'b1;
          queued_r[tid_r] <= 1'b1;
          count_r <= count_r + 1'b1;
        end else if (rem_live) begin
          if (rm_head && rm_tail) bitmap_r[lv_rd] <= 1'b0;
          queued_r[tid_r] <= 1'b0;
          count_r <= count_r - 1'b1;
        end else if (item_r.operation == OP_CLEAR) begin
          bitmap_r <= '0;
          queued_r <= '0;
          count_r <= '0;
        end
      end
      if (cmd.scan_init) begin
        chunk_r <= '0;
        hp_found_r <= 1'b0;
      end else if (cmd.scan && !stat.scan_done) begin
        if (chunk_any) hp_found_r <= 1'b1;
        else chunk_r <= chunk_r + 1'b1;
      end
    end
  end

  always_comb begin
    res.found_thread = found_r;
    res.status = status_r;
    res.highest_priority = hp_found_r ? 6'(hp_r) : 6'd0;
    res.any_ready = hp_found_r;
    res.ready_count = 7'(count_r);
  end
endmodule

@@ hdl/prq_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
`timescale 1ns / 1ps
module prq_ctrl import prq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  prq_stat_t stat,
  output prq_cmd_t  cmd,
  output logic      busy,
  output logic      done
);
  prq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = state_r != S_IDLE;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.latch = start;
        if (start) state_nxt = S_READ;
      end
      S_READ: begin
        // Level ram answers now; head/tail reads go out for that level.
        cmd.rd = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = stat.need_link ? S_LINK : S_SCAN;
        cmd.scan_init = 1'b1;
      end
      S_LINK: begin
        cmd.link = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

@@ hdl/priority_ready_queue.sv @@
// Top level of the priority ready queue.
`timescale 1ns / 1ps
// Usage: raise start with an item on in_data while busy is low; the item is
// taken at that edge and busy rises. Every item yields one result on out_data,
// marked by out_valid for a single cycle; the receiver cannot stall it.
// An item passes through the read and decide steps, then a scan of the bitmap
// in 8-level chunks until the first non-empty level (up to NUM_LEVELS/8
// chunks, rounded up), with a link step before the scan for removal from the
// middle of a list. The link memories have one read and one write port, which
// sets the read, decide and link steps; the scan of the level bitmap, eight
// levels per cycle, sets the rest. Items are handled one at a time: busy falls
// after the result cycle, so the next item can be taken in the cycle after it.
// Reset empties the bitmap, the queued flags and the count at once;
// the link memories need no clearing since only queued entries are read.
// No result is pending after reset.
module priority_ready_queue import prq_pkg::*; #(
  parameter int NUM_LEVELS  = 64,
  parameter int NUM_THREADS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  prq_in_t  in_data,
  output logic     out_valid,
  output prq_out_t out_data
);
  prq_cmd_t  cmd;
  prq_stat_t stat;

  prq_ctrl u_ctrl (.clk, .rst_n, .start, .stat, .cmd, .busy, .done(out_valid));

  prq_datapath #(.NUM_LEVELS(NUM_LEVELS), .NUM_THREADS(NUM_THREADS)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .res(out_data));
endmodule
